FILE: hw/rtl/psfg_pkg.sv
// ----------------------------------------------------------------------------
// psfg_pkg
// types and constants shared by the ppm servo frame generator modules
// ----------------------------------------------------------------------------
package psfg_pkg;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_TICK        = 2'd0,
      REQ_WRITE_US    = 2'd1,
      REQ_WRITE_ANGLE = 2'd2,
      REQ_NONE        = 2'd3
   } req_kind_type;

   // csr register indexes (byte address / 4)
   localparam logic [1:0] CSR_ACTIVE_CHANNELS  = 2'd0;
   localparam logic [1:0] CSR_PULSE_ACTIVE_LOW = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_DISABLED  = 2'd2;

   localparam int WIDTH_W = 10;
   localparam int TICK_W  = 13;
   localparam int SLOT_W  = 4;

   // microsecond limits
   localparam logic signed [15:0] US_WIDE_LO   = 16'sd500;
   localparam logic signed [15:0] US_WIDE_HI   = 16'sd2200;
   localparam logic signed [15:0] US_NARROW_LO = 16'sd1000;
   localparam logic signed [15:0] US_NARROW_HI = 16'sd2000;
   // up to this many active channels every channel gets the wide range
   localparam logic [3:0] WIDE_RANGE_MAX_ACTIVE = 4'd6;

   // angle mapping: width = angle*250/180 + 250
   localparam logic signed [15:0] ANGLE_MAX = 16'sd180;
   // floor(x*25/18) == (x*91025) >> 16 for x in 0..180
   localparam logic [16:0] ANGLE_RECIP  = 17'd91025;
   localparam int          ANGLE_SHIFT  = 16;
   localparam logic [WIDTH_W-1:0] ANGLE_OFFSET = 10'd250;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 10'd200;
   localparam logic [TICK_W-1:0]  PERIOD_RESET = 13'd500;

   // write decision handed from the width calculator to the top level
   typedef struct packed {
      logic               we;
      logic [WIDTH_W-1:0] width;
   } width_wr_type;

endpackage

FILE: hw/rtl/ppm_servo_frame_generator.sv
// ----------------------------------------------------------------------------
// ppm_servo_frame_generator
// multi-channel servo ppm pulse train generator with stream request port
// ----------------------------------------------------------------------------
// Every request transaction is a 4 us timer tick, a channel width write or
// a no-op, and each one produces exactly one response transaction with the
// line level, the current slot and a frame start flag. The block takes one
// request per clock while responses are taken: a request is held in an
// input register, all state updates happen in one pass of logic on the way
// to the response register, and the response register is loaded from the
// input register once the response register is free or draining.
// Throughput is one transaction per cycle as long as the response side
// keeps taking; a stalled response holds the queued request and drops
// req_tready only while both registers are full. The longest path is the
// sync gap computation, an add over all channel widths feeding a subtract
// from the frame length. Widths reset to 200 ticks (800 us) and need no
// clearing pass. Configuration is written through the csr port while the
// block is idle, a rule for the user that the block does not enforce.
// ----------------------------------------------------------------------------
module ppm_servo_frame_generator #(
   parameter int MAX_CHANNELS = 8,
   parameter int PULSE_TICKS  = 50,
   parameter int FRAME_TICKS  = 4999
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] channel, [23:8] value
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] line_level, [4:1] slot_index, [5] frame_start
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import psfg_pkg::*;

   localparam int IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ACT_MAX = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
   localparam logic [3:0]        ACT_MAX_V = 4'(ACT_MAX);
   localparam logic [7:0]        CH_MAX_V  = 8'(MAX_CHANNELS);
   localparam logic [TICK_W-1:0] PULSE_V   = TICK_W'(PULSE_TICKS);
   localparam logic [13:0]       FRAME_V   = 14'(FRAME_TICKS);

   // configuration registers
   logic [3:0] active_ff, active_in;
   logic       pal_ff, pal_in;
   logic       disabled_ff, disabled_in;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_kind_ff;
   logic [7:0]        in_channel_ff;
   logic signed [15:0] in_value_ff;

   // generator state
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  top_ff, top_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [WIDTH_W-1:0] widths_ff [MAX_CHANNELS];

   // response stage
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;

   logic req_fire;
   logic proc;
   logic csr_wr;

   // write path
   logic [7:0]     ch_m1;
   logic [IDX_W-1:0] wr_idx;
   width_wr_type   wr;

   logic [13:0]       width_sum;
   logic [TICK_W-1:0] sync_top;
   logic              wrapped;
   logic              level;

   // handshakes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign req_fire   = req_tvalid && req_tready;
   // the queued request moves on when the response register is free or draining
   assign proc       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign in_valid_in  = req_fire || (in_valid_ff && !proc);
   assign out_valid_in = proc || (out_valid_ff && !rsp_tready);

   // csr write decode with channel count saturation
   always_comb begin
      active_in   = active_ff;
      pal_in      = pal_ff;
      disabled_in = disabled_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_ACTIVE_CHANNELS: begin
               if (csr_pwdata[3:0] == 4'd0) begin
                  active_in = 4'd1;
               end else if (csr_pwdata[3:0] > ACT_MAX_V) begin
                  active_in = ACT_MAX_V;
               end else begin
                  active_in = csr_pwdata[3:0];
               end
            end
            CSR_PULSE_ACTIVE_LOW: begin
               pal_in = csr_pwdata[0];
            end
            CSR_OUTPUT_DISABLED: begin
               disabled_in = csr_pwdata[0];
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   // csr read back
   always_comb begin
      case (csr_paddr[3:2])
         CSR_ACTIVE_CHANNELS:  csr_prdata = {28'd0, active_ff};
         CSR_PULSE_ACTIVE_LOW: csr_prdata = {31'd0, pal_ff};
         CSR_OUTPUT_DISABLED:  csr_prdata = {31'd0, disabled_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // one-based channel number, clamped into the table
   always_comb begin
      ch_m1 = in_channel_ff - 8'd1;
      if (in_channel_ff == 8'd0) begin
         wr_idx = '0;
      end else if (in_channel_ff > CH_MAX_V) begin
         wr_idx = IDX_W'(MAX_CHANNELS - 1);
      end else begin
         wr_idx = ch_m1[IDX_W-1:0];
      end
   end

   psfg_width_calc u_width_calc (
      .req_kind      (in_kind_ff),
      .first_channel (wr_idx == '0),
      .wide_range    (active_ff <= WIDE_RANGE_MAX_ACTIVE),
      .value         (in_value_ff),
      .wr            (wr)
   );

   // sync gap: frame length minus the widths of all active channels
   always_comb begin
      width_sum = '0;
      for (int j = 0; j < MAX_CHANNELS; j++) begin
         if (5'(j) < {1'b0, active_ff}) begin
            width_sum = width_sum + 14'(widths_ff[j]);
         end
      end
      if (width_sum > FRAME_V) begin
         sync_top = '0;
      end else begin
         sync_top = TICK_W'(FRAME_V - width_sum);
      end
   end

   // tick handling: counter wrap, then slot load at the end of the pulse
   always_comb begin
      tick_in = tick_ff;
      top_in  = top_ff;
      slot_in = slot_ff;
      wrapped = 1'b0;
      if (in_kind_ff == REQ_TICK) begin
         if (tick_ff >= top_ff) begin
            tick_in = '0;
         end else begin
            tick_in = tick_ff + 1'b1;
         end
         if (tick_in == PULSE_V) begin
            if (slot_ff >= active_ff) begin
               // past the last active channel: sync gap, new frame
               top_in  = sync_top;
               slot_in = '0;
               wrapped = 1'b1;
            end else begin
               top_in  = TICK_W'(widths_ff[slot_ff[IDX_W-1:0]]);
               slot_in = slot_ff + 1'b1;
            end
         end
      end
   end

   // line level after this transaction
   always_comb begin
      if (disabled_ff) begin
         level = 1'b0;
      end else if (tick_in < PULSE_V) begin
         level = !pal_ff;
      end else begin
         level = pal_ff;
      end
      out_data_in = {2'b00, wrapped, slot_in, level};
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 4'd1;
         pal_ff       <= 1'b1;
         disabled_ff  <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tick_ff      <= '0;
         top_ff       <= PERIOD_RESET;
         slot_ff      <= '0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            widths_ff[i] <= WIDTH_RESET;
         end
      end else begin
         active_ff    <= active_in;
         pal_ff       <= pal_in;
         disabled_ff  <= disabled_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (proc) begin
            tick_ff <= tick_in;
            top_ff  <= top_in;
            slot_ff <= slot_in;
            if (wr.we) begin
               widths_ff[wr_idx] <= wr.width;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff    <= req_tuser;
         in_channel_ff <= req_tdata[7:0];
         in_value_ff   <= req_tdata[23:8];
      end
      if (proc) begin
         out_data_ff <= out_data_in;
      end
   end

   // a frame start is always reported together with slot zero
   a_frame_start_slot0 : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[5]) |-> (rsp_tdata[4:1] == 4'd0))
      else $error("frame start reported with nonzero slot");

   // the slot only advances on the tick that ends a pulse
   a_slot_moves_on_pulse : assert property (@(posedge clock) disable iff (reset)
      (slot_ff != $past(slot_ff)) |-> (tick_ff == PULSE_V))
      else $error("slot changed away from the pulse end");

   // active channel count always stays inside its saturation range
   a_active_range : assert property (@(posedge clock) disable iff (reset)
      (active_ff != 4'd0) && (active_ff <= ACT_MAX_V))
      else $error("active channel count out of range");

   // a request is refused only while one is already queued
   a_ready_queue : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("request refused with a free stage");

endmodule

FILE: hw/rtl/psfg_width_calc.sv
// ----------------------------------------------------------------------------
// psfg_width_calc
// turns a channel write request into a stored width in timer ticks
// ----------------------------------------------------------------------------
module psfg_width_calc (
   input  logic [1:0]             req_kind,
   input  logic                   first_channel,
   input  logic                   wide_range,
   input  logic signed [15:0]     value,
   output psfg_pkg::width_wr_type wr
);
   import psfg_pkg::*;

   logic signed [15:0] us_lo;
   logic signed [15:0] us_hi;
   logic [11:0]        us_clamped;
   logic [7:0]         angle;
   logic [24:0]        angle_prod;
   logic [WIDTH_W-1:0] angle_width;

   always_comb begin
      if (wide_range || first_channel) begin
         us_lo = US_WIDE_LO;
         us_hi = US_WIDE_HI;
      end else begin
         us_lo = US_NARROW_LO;
         us_hi = US_NARROW_HI;
      end
      if (value < us_lo) begin
         us_clamped = us_lo[11:0];
      end else if (value > us_hi) begin
         us_clamped = us_hi[11:0];
      end else begin
         us_clamped = value[11:0];
      end
   end

   always_comb begin
      if (value < 16'sd0) begin
         angle = 8'd0;
      end else if (value > ANGLE_MAX) begin
         angle = ANGLE_MAX[7:0];
      end else begin
         angle = value[7:0];
      end
      angle_prod  = 25'(angle) * 25'(ANGLE_RECIP);
      angle_width = 10'(angle_prod[ANGLE_SHIFT +: 8]) + ANGLE_OFFSET;
   end

   always_comb begin
      wr.we    = 1'b0;
      wr.width = us_clamped[11:2];
      case (req_kind)
         REQ_WRITE_US: begin
            wr.we    = 1'b1;
            wr.width = us_clamped[11:2];
         end
         REQ_WRITE_ANGLE: begin
            wr.we    = 1'b1;
            wr.width = angle_width;
         end
         default: begin
            wr.we = 1'b0;
         end
      endcase
   end

endmodule

FILE: tb/sv/ppm_servo_frame_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_servo_frame_generator_tb
// self-checking stream testbench for the ppm servo frame generator
// ----------------------------------------------------------------------------
// A queue of tick, write and no-op requests feeds a bursty stream driver. A
// behavioral copy of the frame timer (tick counter, period, slot counter and
// channel width table) computes the line level, slot and frame start flag for
// every accepted request, and a monitor compares each response with the
// oldest expected status. Several csr settings are applied between phases.
// The response side stalls on its own pattern and holds off once for a long
// stretch so the request side backs up.
// ----------------------------------------------------------------------------
module ppm_servo_frame_generator_tb;
   import psfg_pkg::*;

   localparam int NUM_SLOTS      = 8;
   localparam int PULSE_LEN      = 50;
   localparam int FRAME_LEN      = 4999;
   localparam int PERIOD_AT_RST  = 500;
   localparam int WIDTH_AT_RST   = 200;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 61;
   localparam int HOLD_START     = 40;
   localparam int HOLD_LEN       = 300;

   // one request transaction as the driver sees it
   typedef struct {
      req_kind_type      kind;
      logic [7:0]        channel;
      logic signed [15:0] value;
   } servo_req_type;

   // one response transaction, field by field
   typedef struct packed {
      logic       level;
      logic [3:0] slot;
      logic       frame_start;
   } line_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] channel, [23:8] value
   logic [1:0]  req_tuser = '0;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] line_level, [4:1] slot_index, [5] frame_start
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ppm_servo_frame_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // reset held only at the start of the run
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // generous hard limit, well above the slowest legal run
   initial begin
      #40_000_000;
      $display("ppm_servo_frame_generator_tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // frame timer model state
   // ---------------------------------------------------------------------
   int         cfg_channels;
   logic       cfg_active_low;
   logic       cfg_disabled;
   logic [12:0] tick_count;
   logic [12:0] period_len;
   logic [3:0]  slot_cnt;
   logic [9:0]  width_ticks [NUM_SLOTS];

   servo_req_type   pending_reqs [$];
   line_status_type status_q [$];
   int              err_count = 0;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // applies one request to the timer model and returns the status it reports
   function automatic line_status_type advance_servo(servo_req_type r);
      int              idx;
      int              us;
      int              ang;
      int              sum;
      line_status_type s;
      s.frame_start = 1'b0;
      // one-based channel number, out of range goes to the nearest end
      if (r.channel == 0) idx = 0;
      else if (r.channel > NUM_SLOTS) idx = NUM_SLOTS - 1;
      else idx = int'(r.channel) - 1;
      case (r.kind)
         REQ_TICK: begin
            if (tick_count >= period_len) tick_count = '0;
            else tick_count = tick_count + 13'd1;
            // the next period is loaded when the separator pulse ends
            if (tick_count == PULSE_LEN) begin
               if (int'(slot_cnt) + 1 >= cfg_channels + 1) begin
                  // sync gap fills the frame up to its fixed length
                  sum = 0;
                  for (int j = 0; j < cfg_channels && j < NUM_SLOTS; j++)
                     sum += int'(width_ticks[j]);
                  period_len = (sum > FRAME_LEN) ? 13'd0 : 13'(FRAME_LEN - sum);
                  slot_cnt = '0;
                  s.frame_start = 1'b1;
               end else begin
                  period_len = (slot_cnt < NUM_SLOTS) ?
                               13'(width_ticks[slot_cnt[2:0]]) : 13'd0;
                  slot_cnt = slot_cnt + 4'd1;
               end
            end
         end
         REQ_WRITE_US: begin
            // channel 1 and small frames keep the wide range
            if (cfg_channels <= 6 || idx == 0) us = clamp_int(int'(r.value), 500, 2200);
            else us = clamp_int(int'(r.value), 1000, 2000);
            width_ticks[idx] = 10'(us / 4);
         end
         REQ_WRITE_ANGLE: begin
            ang = clamp_int(int'(r.value), 0, 180);
            width_ticks[idx] = 10'(ang * 250 / 180 + 250);
         end
         default: ;
      endcase
      if (cfg_disabled) s.level = 1'b0;
      else if (tick_count < PULSE_LEN) s.level = ~cfg_active_low;
      else s.level = cfg_active_low;
      s.slot = slot_cnt;
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // request driver: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------
   servo_req_type req_held;
   int            burst_left = 1;
   int            gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // accepted transaction goes through the model in acceptance order
         if (req_tvalid && req_tready)
            status_q.push_back(advance_servo(req_held));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               req_held = pending_reqs.pop_front();
               req_tdata <= {req_held.value, req_held.channel};
               req_tuser <= req_held.kind;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  // about a quarter of the bursts follow on with no gap
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response side: stall pattern of its own plus one long hold-off
   // ---------------------------------------------------------------------
   int rx_cycle = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   always @(posedge clock) begin
      rx_cycle++;
      if (rx_mode_left <= 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_mode_left = $urandom_range(5, 80);
      end else begin
         rx_mode_left--;
      end
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
         // long hold-off so the block fills up and drops req_tready
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every response against the oldest expected status
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      line_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_q.size() == 0) begin
            $error("response transaction with nothing expected: tdata %h", rsp_tdata);
            err_count++;
         end else begin
            want = status_q.pop_front();
            if (rsp_tdata[0] !== want.level) begin
               $error("line_level: expected %0d, got %0d", want.level, rsp_tdata[0]);
               err_count++;
            end
            if (rsp_tdata[4:1] !== want.slot) begin
               $error("slot_index: expected %0d, got %0d", want.slot, rsp_tdata[4:1]);
               err_count++;
            end
            if (rsp_tdata[5] !== want.frame_start) begin
               $error("frame_start: expected %0d, got %0d", want.frame_start, rsp_tdata[5]);
               err_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_req(req_kind_type kind, int channel, int value);
      servo_req_type r;
      r.kind = kind;
      r.channel = 8'(channel);
      r.value = 16'(value);
      pending_reqs.push_back(r);
   endtask

   // mostly ticks so frames run through, writes with edge-heavy values
   task automatic queue_random(int count);
      servo_req_type r;
      int            pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         r.kind = (pick < 88) ? REQ_TICK :
                  (pick < 94) ? REQ_WRITE_US :
                  (pick < 98) ? REQ_WRITE_ANGLE : REQ_NONE;
         r.channel = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
         case ($urandom_range(0, 7))
            0:       r.value = 16'($urandom);
            1, 2:    r.value = 16'(int'($urandom_range(0, 220)) - 20);
            default: r.value = 16'($urandom_range(400, 2400));
         endcase
         pending_reqs.push_back(r);
      end
   endtask

   // nothing queued and nothing in flight
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_tvalid || status_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle then access cycle, model follows at the access edge
   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         CSR_ACTIVE_CHANNELS:  cfg_channels = clamp_int(int'(data[3:0]), 1, NUM_SLOTS);
         CSR_PULSE_ACTIVE_LOW: cfg_active_low = data[0];
         CSR_OUTPUT_DISABLED:  cfg_disabled = data[0];
         default: ;
      endcase
   endtask

   // new settings while idle, then a run of random traffic
   task automatic run_phase(logic [31:0] channels, logic [31:0] active_low,
                            logic [31:0] disabled);
      wait_idle();
      csr_write(CSR_ACTIVE_CHANNELS, channels);
      csr_write(CSR_PULSE_ACTIVE_LOW, active_low);
      csr_write(CSR_OUTPUT_DISABLED, disabled);
      queue_random(PHASE_ITEMS);
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      // model state after reset
      cfg_channels = 1;
      cfg_active_low = 1'b1;
      cfg_disabled = 1'b0;
      tick_count = '0;
      period_len = 13'(PERIOD_AT_RST);
      slot_cnt = '0;
      for (int i = 0; i < NUM_SLOTS; i++) width_ticks[i] = 10'(WIDTH_AT_RST);

      while (reset) @(posedge clock);

      // directed: field extremes, channel clamps, range and angle clamps
      queue_req(REQ_TICK, 0, 0);
      queue_req(REQ_TICK, 255, -1);
      queue_req(REQ_WRITE_US, 0, -32768);      // channel 0 maps to channel 1
      queue_req(REQ_WRITE_US, 1, 499);
      queue_req(REQ_WRITE_US, 2, 500);
      queue_req(REQ_WRITE_US, 8, 2200);
      queue_req(REQ_WRITE_US, 9, 2201);        // above last channel
      queue_req(REQ_WRITE_US, 255, 32767);
      queue_req(REQ_WRITE_ANGLE, 3, -1);       // negative angle floors at 0
      queue_req(REQ_WRITE_ANGLE, 4, 0);
      queue_req(REQ_WRITE_ANGLE, 5, 180);
      queue_req(REQ_WRITE_ANGLE, 6, 181);
      queue_req(REQ_WRITE_ANGLE, 7, 91);
      queue_req(REQ_WRITE_ANGLE, 0, 32767);
      queue_req(REQ_WRITE_ANGLE, 200, -32768);
      queue_req(REQ_NONE, 255, -1);            // unknown request leaves state alone
      queue_req(REQ_NONE, 0, 0);
      queue_req(REQ_TICK, 170, 21845);
      queue_req(REQ_TICK, 85, -21846);
      queue_req(REQ_WRITE_US, 1, 1000);

      // default settings first, the long hold-off lands in here
      queue_random(PHASE_ITEMS);

      // zero clamps up to one channel, line forced low
      run_phase(32'h0000_0000, 32'h0, 32'h1);
      // all ones in the count field clamps to the full frame, narrow range
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      // largest count that keeps the wide range, active high pulse
      run_phase(32'd6, 32'h0, 32'h0);
      // narrow range again, upper bits of the data ignored
      run_phase(32'hFFFF_FFF7, 32'h1, 32'hFFFF_FFFF);
      run_phase(32'd8, 32'h0, 32'h0);
      run_phase(32'd3, 32'h1, 32'h0);

      wait_idle();
      if (err_count == 0 && status_q.size() == 0) begin
         $display("ppm_servo_frame_generator_tb: clean");
      end else begin
         $display("ppm_servo_frame_generator_tb: errors");
      end
      $finish;
   end

endmodule
